// ===== rtl/svg_pkg.sv =====
`default_nettype none

package svg_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_HALF_COUNT  = 64;
  localparam int DEF_TRIG_TABLE_BITS = 10;

  // Port field widths
  localparam int IDX_W      = 7;
  localparam int FIELD_W    = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int RADIUS_W   = 15;
  localparam int STEP_W     = 16;
  localparam int HALF_W     = 7;

  localparam logic [RADIUS_W-1:0] RADIUS_RST = 15'd256;
  localparam logic [STEP_W-1:0]   STEP_RST   = 16'd2048;
  localparam logic [HALF_W-1:0]   HALF_RST   = 7'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS = 8'd0,
    REG_STEP   = 8'd1,
    REG_HSEG   = 8'd2,
    REG_HSLICE = 8'd3
  } cfg_reg_t;

  // Texture coordinate divider
  localparam int UV_Q_W        = 21;
  localparam int UV_DIV_PER    = 7;
  localparam int UV_DIV_STAGES = 3;

  // Normalize unit
  localparam int NORM_IN_W   = 34;
  localparam int MAG_W       = 33;
  localparam int NMS_W       = 30;
  localparam int LEN2_W      = 62;
  localparam int SQ_W        = 64;
  localparam int SQRT_PER    = 4;
  localparam int SQRT_STAGES = 8;
  localparam int LEN_W       = 31;
  localparam int NDIV_BITS   = 15;
  localparam int NDIV_PER    = 5;
  localparam int NDIV_STAGES = 3;
  localparam int NREM_W      = 46;
  localparam int NORM_LAT    = 5 + SQRT_STAGES + NDIV_STAGES + 1;

  // Front stages A..G ahead of the normalize unit
  localparam int FRONT_LAT = 7;
  localparam int PIPE_LAT  = FRONT_LAT + NORM_LAT;

  localparam logic [14:0] UNIT_Q14 = 15'd16384;

  typedef struct packed {
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] pos_z;
    logic signed [FIELD_W-1:0] tex_u;
    logic signed [FIELD_W-1:0] tex_v;
    logic                      upper;
  } vtx_t;

  typedef struct packed {
    logic [1:0][UV_Q_W-1:0] rem;
    logic [1:0][UV_Q_W-1:0] quo;
    logic [1:0][HALF_W-1:0] den;
    logic [1:0]             neg;
    logic [1:0]             dz;
    logic                   upper;
  } uv_t;

  typedef struct packed {
    logic [SQ_W-1:0]        v;
    logic [SQ_W-1:0]        res;
    logic [2:0][NMS_W-1:0]  ms;
    logic [2:0]             neg;
    logic                   zero;
  } sqrt_t;

  typedef struct packed {
    logic [2:0][NREM_W-1:0]    rem;
    logic [2:0][NDIV_BITS-1:0] quo;
    logic [LEN_W-1:0]          len;
    logic [2:0]                neg;
    logic                      zero;
  } ndiv_t;

  // Quarter-wave sine in Q1.14, odd Taylor series in Q30
  function automatic logic [14:0] sine_quarter(logic [14:0] x);
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] p;
    logic [63:0] r;
    t  = 64'(x) << 16;
    t2 = (t * t) >> 30;
    p  = 64'd172273;
    p  = 64'd5026995 - ((p * t2) >> 30);
    p  = 64'd85569306 - ((p * t2) >> 30);
    p  = 64'd693598669 - ((p * t2) >> 30);
    p  = 64'd1686629713 - ((p * t2) >> 30);
    r  = (p * t) >> 30;
    r  = (r + 64'd32768) >> 16;
    if (r > 64'd16384) begin
      r = 64'd16384;
    end
    return r[14:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/svg_in_if.sv =====
`default_nettype none

interface svg_in_if import svg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [IDX_W-1:0] lat_index;
  logic signed [IDX_W-1:0] lon_index;

  modport source (output valid, lat_index, lon_index, input ready);
  modport sink   (input valid, lat_index, lon_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/svg_out_if.sv =====
`default_nettype none

interface svg_out_if import svg_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] pos_x;
  logic signed [FIELD_W-1:0] pos_y;
  logic signed [FIELD_W-1:0] pos_z;
  logic signed [FIELD_W-1:0] tex_u;
  logic signed [FIELD_W-1:0] tex_v;
  logic signed [FIELD_W-1:0] tan_x;
  logic signed [FIELD_W-1:0] tan_y;
  logic signed [FIELD_W-1:0] tan_z;
  logic signed [FIELD_W-1:0] bitan_x;
  logic signed [FIELD_W-1:0] bitan_y;
  logic signed [FIELD_W-1:0] bitan_z;
  logic                      upper_row;

  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, tan_x, tan_y, tan_z,
                  bitan_x, bitan_y, bitan_z, upper_row, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, tan_x, tan_y, tan_z,
                  bitan_x, bitan_y, bitan_z, upper_row, output ready);
endinterface

`default_nettype wire

// ===== rtl/svg_cfg_if.sv =====
`default_nettype none

interface svg_cfg_if import svg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/svg_norm.sv =====
`default_nettype none

module svg_norm import svg_pkg::*; (
  input  logic                             clk,
  input  logic                             en,
  input  logic [2:0][NORM_IN_W-1:0]        vec_i,
  output logic [2:0][FIELD_W-1:0]          unit_o
);

  logic [2:0][MAG_W-1:0]      s1_m_r;
  logic [2:0]                 s1_neg_r;
  logic [MAG_W-1:0]           s1_mx_r;
  logic [2:0][MAG_W-1:0]      s2_m_r;
  logic [2:0]                 s2_neg_r;
  logic [5:0]                 s2_lead_r;
  logic                       s2_zero_r;
  logic [2:0][NMS_W-1:0]      s3_ms_r;
  logic [2:0]                 s3_neg_r;
  logic                       s3_zero_r;
  logic [2:0][2*NMS_W-1:0]    s4_sq_r;
  logic [2:0][NMS_W-1:0]      s4_ms_r;
  logic [2:0]                 s4_neg_r;
  logic                       s4_zero_r;
  sqrt_t                      s5_r;
  sqrt_t                      sq_r  [SQRT_STAGES];
  sqrt_t                      sq_nxt[SQRT_STAGES];
  ndiv_t                      dv_r  [NDIV_STAGES];
  ndiv_t                      dv_nxt[NDIV_STAGES];
  ndiv_t                      dv_first;
  logic [2:0][FIELD_W-1:0]    unit_r;

  logic [2:0][MAG_W-1:0]      m_nxt;
  logic [MAG_W-1:0]           mx_nxt;
  logic [5:0]                 lead_nxt;
  logic [2:0][NMS_W-1:0]      ms_nxt;
  logic [2:0][FIELD_W-1:0]    unit_nxt;

  // SQRT_PER bit pairs of the integer square root per step
  function automatic sqrt_t sqrt_step(sqrt_t x, int k);
    sqrt_t           y;
    logic [SQ_W-1:0] b;
    y = x;
    for (int s = 0; s < SQRT_PER; s++) begin
      b = SQ_W'(1) << (62 - 2 * (k * SQRT_PER + s));
      if (y.v >= y.res + b) begin
        y.v   = y.v - (y.res + b);
        y.res = (y.res >> 1) + b;
      end else begin
        y.res = y.res >> 1;
      end
    end
    return y;
  endfunction

  // Restoring division, NDIV_PER quotient bits per step
  function automatic ndiv_t ndiv_step(ndiv_t x, int k);
    ndiv_t y;
    int    j;
    y = x;
    for (int s = 0; s < NDIV_PER; s++) begin
      j = NDIV_BITS - 1 - (k * NDIV_PER + s);
      for (int c = 0; c < 3; c++) begin
        if (y.rem[c] >= (NREM_W'(y.len) << j)) begin
          y.rem[c]    = y.rem[c] - (NREM_W'(y.len) << j);
          y.quo[c][j] = 1'b1;
        end
      end
    end
    return y;
  endfunction

  always_comb begin
    mx_nxt = '0;
    for (int c = 0; c < 3; c++) begin
      m_nxt[c] = vec_i[c][NORM_IN_W-1] ? MAG_W'(-vec_i[c]) : MAG_W'(vec_i[c]);
      if (m_nxt[c] > mx_nxt) begin
        mx_nxt = m_nxt[c];
      end
    end
  end

  always_comb begin
    lead_nxt = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (s1_mx_r[b]) begin
        lead_nxt = 6'(b);
      end
    end
  end

  // Bring the largest magnitude into [2^29, 2^30)
  always_comb begin
    logic [MAG_W-1:0] sh;
    for (int c = 0; c < 3; c++) begin
      if (s2_lead_r > 6'd29) begin
        sh = s2_m_r[c] >> (s2_lead_r - 6'd29);
      end else begin
        sh = s2_m_r[c] << (6'd29 - s2_lead_r);
      end
      ms_nxt[c] = sh[NMS_W-1:0];
    end
  end

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    if (k == 0) begin : g_first
      assign sq_nxt[k] = sqrt_step(s5_r, k);
    end else begin : g_next
      assign sq_nxt[k] = sqrt_step(sq_r[k-1], k);
    end
  end

  always_comb begin
    dv_first.len  = sq_r[SQRT_STAGES-1].res[LEN_W-1:0];
    dv_first.neg  = sq_r[SQRT_STAGES-1].neg;
    dv_first.zero = sq_r[SQRT_STAGES-1].zero;
    dv_first.quo  = '0;
    for (int c = 0; c < 3; c++) begin
      dv_first.rem[c] = (NREM_W'(sq_r[SQRT_STAGES-1].ms[c]) << 14)
                        + NREM_W'(dv_first.len >> 1);
    end
  end

  for (genvar k = 0; k < NDIV_STAGES; k++) begin : g_div
    if (k == 0) begin : g_first
      assign dv_nxt[k] = ndiv_step(dv_first, k);
    end else begin : g_next
      assign dv_nxt[k] = ndiv_step(dv_r[k-1], k);
    end
  end

  always_comb begin
    logic [NDIV_BITS-1:0] q;
    for (int c = 0; c < 3; c++) begin
      q = dv_r[NDIV_STAGES-1].quo[c];
      if (q > UNIT_Q14) begin
        q = UNIT_Q14;
      end
      if (dv_r[NDIV_STAGES-1].zero) begin
        unit_nxt[c] = '0;
      end else if (dv_r[NDIV_STAGES-1].neg[c]) begin
        unit_nxt[c] = -FIELD_W'(q);
      end else begin
        unit_nxt[c] = FIELD_W'(q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_m_r    <= m_nxt;
      s1_mx_r   <= mx_nxt;
      for (int c = 0; c < 3; c++) begin
        s1_neg_r[c] <= vec_i[c][NORM_IN_W-1];
      end
      s2_m_r    <= s1_m_r;
      s2_neg_r  <= s1_neg_r;
      s2_lead_r <= lead_nxt;
      s2_zero_r <= (s1_mx_r == '0);
      s3_ms_r   <= ms_nxt;
      s3_neg_r  <= s2_neg_r;
      s3_zero_r <= s2_zero_r;
      for (int c = 0; c < 3; c++) begin
        s4_sq_r[c] <= s3_ms_r[c] * s3_ms_r[c];
      end
      s4_ms_r   <= s3_ms_r;
      s4_neg_r  <= s3_neg_r;
      s4_zero_r <= s3_zero_r;
      s5_r.v    <= SQ_W'(LEN2_W'(s4_sq_r[0]) + LEN2_W'(s4_sq_r[1]) + LEN2_W'(s4_sq_r[2]));
      s5_r.res  <= '0;
      s5_r.ms   <= s4_ms_r;
      s5_r.neg  <= s4_neg_r;
      s5_r.zero <= s4_zero_r;
      for (int k = 0; k < SQRT_STAGES; k++) begin
        sq_r[k] <= sq_nxt[k];
      end
      for (int k = 0; k < NDIV_STAGES; k++) begin
        dv_r[k] <= dv_nxt[k];
      end
      unit_r <= unit_nxt;
    end
  end

  assign unit_o = unit_r;

endmodule

`default_nettype wire

// ===== rtl/sphere_vertex_generator.sv =====
`default_nettype none

// UV-sphere vertex generator. Each accepted request (latitude row, longitude
// column) yields two vertices on the result channel, row y first and row y+1
// second (upper_row set), each with Q8.8 position, Q1.14 uv, unit tangent and
// unit bitangent. A request is held until both of its vertices have issued,
// and one vertex enters the pipeline each cycle unless the result channel
// stalls; the request rate is set by the two-vertex issue register at the
// input. The pipeline runs through front stages A..G and the normalize unit,
// whose depth is dominated by the integer square root and divider. Sine and
// cosine come from a quarter-wave table of 2^(TRIG_TABLE_BITS-2)+1 entries.
// Write configuration only while idle; the configuration port always accepts.
module sphere_vertex_generator import svg_pkg::*; #(
  parameter int MAX_HALF_COUNT  = DEF_MAX_HALF_COUNT,
  parameter int TRIG_TABLE_BITS = DEF_TRIG_TABLE_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  svg_cfg_if.sink   cfg_ch,
  svg_in_if.sink    in_ch,
  svg_out_if.source out_ch
);

  localparam int QN   = 1 << (TRIG_TABLE_BITS - 2);
  localparam int QI_W = TRIG_TABLE_BITS - 1;

  logic [RADIUS_W-1:0]          radius_r;
  logic [STEP_W-1:0]            step_r;
  logic [HALF_W-1:0]            hseg_r;
  logic [HALF_W-1:0]            hsli_r;

  logic                         busy_r;
  logic                         phase_r;
  logic signed [IDX_W-1:0]      lat_r;
  logic signed [IDX_W-1:0]      lon_r;

  logic                         adv;
  logic                         in_take;
  logic signed [7:0]            row_s;
  logic signed [7:0]            col_s;

  logic [1:0][STEP_W-1:0]       a_ang_r;
  uv_t                          a_uv_r;
  uv_t                          a_uv_nxt;
  uv_t                          uv_r  [UV_DIV_STAGES];
  uv_t                          uv_nxt[UV_DIV_STAGES];

  logic [14:0]                  sin_tab [QN+1];
  logic [3:0][FIELD_W-1:0]      trig_nxt;
  logic signed [FIELD_W-1:0]    b_trig_r [4];

  logic signed [31:0]           c_pcc_r;
  logic signed [31:0]           c_psc_r;
  logic signed [31:0]           c_pry_r;
  logic signed [47:0]           d_px_r;
  logic signed [47:0]           d_pz_r;
  logic signed [FIELD_W-1:0]    d_py_r;

  vtx_t                         e_vtx_r;
  vtx_t                         e_vtx_nxt;
  vtx_t                         f_vtx_r;
  logic signed [31:0]           f_bxz_r;
  logic signed [31:0]           f_byz_r;
  logic signed [31:0]           f_sqx_r;
  logic signed [31:0]           f_sqy_r;
  vtx_t                         g_vtx_r;
  logic [2:0][NORM_IN_W-1:0]    g_tan_r;
  logic [2:0][NORM_IN_W-1:0]    g_bit_r;

  vtx_t                         dly_r [NORM_LAT];
  logic [PIPE_LAT-1:0]          vld_r;

  logic [2:0][FIELD_W-1:0]      tan_unit;
  logic [2:0][FIELD_W-1:0]      bit_unit;

  logic                         out_valid_r;
  vtx_t                         out_vtx_r;
  logic [2:0][FIELD_W-1:0]      out_tan_r;
  logic [2:0][FIELD_W-1:0]      out_bit_r;

  function automatic logic [HALF_W-1:0] clamp_den(logic [HALF_W-1:0] d);
    if (int'(d) > MAX_HALF_COUNT) begin
      return HALF_W'(MAX_HALF_COUNT);
    end
    return d;
  endfunction

  // Round to nearest, ties away from zero
  function automatic logic signed [FIELD_W-1:0] round_q28(logic signed [47:0] v);
    logic [47:0] m;
    m = v[47] ? 48'(-v) : 48'(v);
    m = (m + 48'(1 << 27)) >> 28;
    return v[47] ? -FIELD_W'(m) : FIELD_W'(m);
  endfunction

  function automatic logic signed [FIELD_W-1:0] round_q14(logic signed [31:0] v);
    logic [31:0] m;
    m = v[31] ? 32'(-v) : 32'(v);
    m = (m + 32'(1 << 13)) >> 14;
    return v[31] ? -FIELD_W'(m) : FIELD_W'(m);
  endfunction

  function automatic logic signed [FIELD_W-1:0] sat_uv(logic [UV_Q_W-1:0] q, logic neg,
                                                      logic dz);
    if (dz) begin
      return '0;
    end else if (!neg) begin
      return (q > UV_Q_W'(32767)) ? FIELD_W'(32767) : FIELD_W'(q);
    end else begin
      return (q > UV_Q_W'(32768)) ? FIELD_W'(16'h8000) : -FIELD_W'(q);
    end
  endfunction

  function automatic uv_t uv_step(uv_t x, int k);
    uv_t y;
    int  j;
    y = x;
    for (int s = 0; s < UV_DIV_PER; s++) begin
      j = UV_Q_W - 1 - (k * UV_DIV_PER + s);
      for (int c = 0; c < 2; c++) begin
        if ({7'b0, y.rem[c]} >= ({21'b0, y.den[c]} << j)) begin
          y.rem[c]    = y.rem[c] - UV_Q_W'({21'b0, y.den[c]} << j);
          y.quo[c][j] = 1'b1;
        end
      end
    end
    return y;
  endfunction

  // Configuration
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      step_r   <= STEP_RST;
      hseg_r   <= HALF_RST;
      hsli_r   <= HALF_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_RADIUS: radius_r <= cfg_ch.data[RADIUS_W-1:0];
        REG_STEP:   step_r   <= cfg_ch.data[STEP_W-1:0];
        REG_HSEG:   hseg_r   <= cfg_ch.data[HALF_W-1:0];
        REG_HSLICE: hsli_r   <= cfg_ch.data[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  // Issue: hold a request for both of its vertices, lower vertex then upper
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !busy_r || (phase_r && adv);
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= 1'b0;
    end else if (in_take) begin
      busy_r  <= 1'b1;
      phase_r <= 1'b0;
    end else if (adv && busy_r) begin
      busy_r  <= !phase_r;
      phase_r <= !phase_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      lat_r <= in_ch.lat_index;
      lon_r <= in_ch.lon_index;
    end
  end

  assign row_s = {lat_r[IDX_W-1], lat_r} + {7'b0, phase_r};
  assign col_s = {lon_r[IDX_W-1], lon_r};

  // Stage A inputs: uv dividend and divisor
  always_comb begin
    logic [7:0]        mag;
    logic [HALF_W-1:0] den;
    a_uv_nxt       = '0;
    a_uv_nxt.upper = phase_r;
    mag = col_s[7] ? 8'(-col_s) : 8'(col_s);
    den = clamp_den(hseg_r);
    a_uv_nxt.rem[0] = {mag[6:0], 14'b0} + UV_Q_W'(den >> 1);
    a_uv_nxt.den[0] = den;
    a_uv_nxt.neg[0] = col_s[7];
    a_uv_nxt.dz[0]  = (hseg_r == '0);
    mag = row_s[7] ? 8'(-row_s) : 8'(row_s);
    den = clamp_den(hsli_r);
    a_uv_nxt.rem[1] = {mag[6:0], 14'b0} + UV_Q_W'(den >> 1);
    a_uv_nxt.den[1] = den;
    a_uv_nxt.neg[1] = row_s[7];
    a_uv_nxt.dz[1]  = (hsli_r == '0);
  end

  for (genvar k = 0; k < UV_DIV_STAGES; k++) begin : g_uvdiv
    if (k == 0) begin : g_first
      assign uv_nxt[k] = uv_step(a_uv_r, k);
    end else begin : g_next
      assign uv_nxt[k] = uv_step(uv_r[k-1], k);
    end
  end

  // Quarter-wave sine table
  for (genvar t = 0; t <= QN; t++) begin : g_tab
    assign sin_tab[t] = sine_quarter(15'(t << (16 - TRIG_TABLE_BITS)));
  end

  // Lookups: sin row, cos row, sin col, cos col
  for (genvar g = 0; g < 4; g++) begin : g_trig
    logic [STEP_W-1:0]             ang;
    logic [TRIG_TABLE_BITS-3:0]    kq;
    logic [QI_W-1:0]               idx;
    logic [14:0]                   mag;
    assign ang = (g % 2 == 1) ? a_ang_r[g/2] + 16'h4000 : a_ang_r[g/2];
    assign kq  = ang[13 -: TRIG_TABLE_BITS-2];
    assign idx = ang[14] ? QI_W'(QN) - {1'b0, kq} : {1'b0, kq};
    assign mag = sin_tab[idx];
    assign trig_nxt[g] = ang[15] ? -{1'b0, mag} : {1'b0, mag};
  end

  always_comb begin
    e_vtx_nxt.pos_x = round_q28(d_px_r);
    e_vtx_nxt.pos_y = d_py_r;
    e_vtx_nxt.pos_z = round_q28(d_pz_r);
    e_vtx_nxt.tex_u = sat_uv(uv_r[UV_DIV_STAGES-1].quo[0], uv_r[UV_DIV_STAGES-1].neg[0],
                             uv_r[UV_DIV_STAGES-1].dz[0]);
    e_vtx_nxt.tex_v = sat_uv(uv_r[UV_DIV_STAGES-1].quo[1], uv_r[UV_DIV_STAGES-1].neg[1],
                             uv_r[UV_DIV_STAGES-1].dz[1]);
    e_vtx_nxt.upper = uv_r[UV_DIV_STAGES-1].upper;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // A: angles
      a_ang_r[0] <= {{8{row_s[7]}}, row_s} * step_r;
      a_ang_r[1] <= {{8{col_s[7]}}, col_s} * step_r;
      a_uv_r     <= a_uv_nxt;
      for (int k = 0; k < UV_DIV_STAGES; k++) begin
        uv_r[k] <= uv_nxt[k];
      end
      // B: table
      for (int g = 0; g < 4; g++) begin
        b_trig_r[g] <= $signed(trig_nxt[g]);
      end
      // C: trig products
      c_pcc_r <= b_trig_r[3] * b_trig_r[1];
      c_psc_r <= b_trig_r[2] * b_trig_r[1];
      c_pry_r <= $signed({1'b0, radius_r}) * b_trig_r[0];
      // D: scale by radius
      d_px_r  <= $signed({1'b0, radius_r}) * c_pcc_r;
      d_pz_r  <= $signed({1'b0, radius_r}) * c_psc_r;
      d_py_r  <= round_q14(c_pry_r);
      // E: rounded position and uv
      e_vtx_r <= e_vtx_nxt;
      // F: bitangent products
      f_vtx_r <= e_vtx_r;
      f_bxz_r <= e_vtx_r.pos_x * e_vtx_r.pos_z;
      f_byz_r <= e_vtx_r.pos_y * e_vtx_r.pos_z;
      f_sqx_r <= e_vtx_r.pos_x * e_vtx_r.pos_x;
      f_sqy_r <= e_vtx_r.pos_y * e_vtx_r.pos_y;
      // G: vectors for the normalize units
      g_vtx_r    <= f_vtx_r;
      g_tan_r[0] <= NORM_IN_W'(f_vtx_r.pos_y);
      g_tan_r[1] <= -NORM_IN_W'(f_vtx_r.pos_x);
      g_tan_r[2] <= '0;
      g_bit_r[0] <= NORM_IN_W'(f_bxz_r);
      g_bit_r[1] <= NORM_IN_W'(f_byz_r);
      g_bit_r[2] <= -(NORM_IN_W'(f_sqx_r) + NORM_IN_W'(f_sqy_r));
      // Align with the normalize units
      dly_r[0] <= g_vtx_r;
      for (int k = 1; k < NORM_LAT; k++) begin
        dly_r[k] <= dly_r[k-1];
      end
      out_vtx_r <= dly_r[NORM_LAT-1];
      out_tan_r <= tan_unit;
      out_bit_r <= bit_unit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[PIPE_LAT-2:0], busy_r};
      out_valid_r <= vld_r[PIPE_LAT-1];
    end
  end

  svg_norm u_tan_norm (
    .clk    (clk),
    .en     (adv),
    .vec_i  (g_tan_r),
    .unit_o (tan_unit)
  );

  svg_norm u_bit_norm (
    .clk    (clk),
    .en     (adv),
    .vec_i  (g_bit_r),
    .unit_o (bit_unit)
  );

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pos_x     = out_vtx_r.pos_x;
  assign out_ch.pos_y     = out_vtx_r.pos_y;
  assign out_ch.pos_z     = out_vtx_r.pos_z;
  assign out_ch.tex_u     = out_vtx_r.tex_u;
  assign out_ch.tex_v     = out_vtx_r.tex_v;
  assign out_ch.tan_x     = $signed(out_tan_r[0]);
  assign out_ch.tan_y     = $signed(out_tan_r[1]);
  assign out_ch.tan_z     = $signed(out_tan_r[2]);
  assign out_ch.bitan_x   = $signed(out_bit_r[0]);
  assign out_ch.bitan_y   = $signed(out_bit_r[1]);
  assign out_ch.bitan_z   = $signed(out_bit_r[2]);
  assign out_ch.upper_row = out_vtx_r.upper;

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !phase_r && adv) |=> (busy_r && phase_r))
    else $error("upper vertex of a request was not issued after the lower one");

  a_take_starts_pair: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (busy_r && !phase_r))
    else $error("accepted request did not start with the lower vertex");

  a_flat_tangent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_ch.tan_z == '0))
    else $error("tangent z component is not zero");

  a_zero_vectors: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ch.pos_x == '0 && out_ch.pos_y == '0 && out_ch.pos_z == '0)
    |-> (out_ch.tan_x == '0 && out_ch.tan_y == '0 && out_ch.bitan_x == '0 &&
         out_ch.bitan_y == '0 && out_ch.bitan_z == '0))
    else $error("zero position produced a nonzero tangent frame");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid_r)
    else $error("result valid after reset");

endmodule

`default_nettype wire
